>>> design/mfr_pkg.sv
package mfr_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_PAGES   = 8;
    localparam int SCREEN_ROWS    = 8 * SCREEN_PAGES;
    localparam int STORE_DEPTH    = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int COL_W          = $clog2(SCREEN_COLUMNS);
    localparam int PAGE_W         = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

    typedef enum logic [2:0] {
        REQ_POINT = 3'd0,
        REQ_LINE  = 3'd1,
        REQ_ARC   = 3'd2,
        REQ_FILL  = 3'd3,
        REQ_READ  = 3'd4
    } req_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request fields, init stepping state
        logic clr_addr;  // reset clear sweep address
        logic clr_step;  // write zero at sweep address and advance
        logic probe;     // compute current plot address, issue read
        logic write;     // write modified byte
        logic advance;   // advance the walker one plot
        logic rd_issue;  // issue read for the read request
        logic rd_take;   // latch read data into result
        logic res_zero;  // result for non-read request
    } mfr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic done;      // walker has no more plots
        logic in_range;  // current plot lands in the store
    } mfr_stat_t;

endpackage

>>> design/mono_framebuffer_rasterizer.sv
// 128x64 monochrome frame store (8 pages of column bytes) with a point, line, quarter-arc, fill
// and byte-read engine. Every request gives one result; only a read carries data. Each plotted
// pixel is a read-modify-write of the store, which has one read and one write port: a probe
// state issues the read and a write state writes the modified byte. A line plots
// max(|dx|,|dy|)+2 points, an arc two per step of its octant walk, a fill width*height; an
// empty arc or fill and an unknown request plot none. A new request is not taken until the
// last result is raised, nor while that result is stalled. After reset the store is swept to
// zero, and no request is taken until the sweep ends.
module mono_framebuffer_rasterizer
    import mfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] req_type,
    input  logic [7:0] x_a,
    input  logic [7:0] y_a,
    input  logic [7:0] x_b,
    input  logic [7:0] y_b,
    input  logic [7:0] radius,
    input  logic [2:0] quadrant,
    input  logic       dot,
    input  logic [2:0] read_page,
    input  logic [6:0] read_column,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_byte,
    output logic       is_read
);
    mfr_cmd_t  cmd;
    mfr_stat_t stat;

    mfr_ctrl u_ctrl (
        .clk (clk), .rst_n (rst_n),
        .in_valid (in_valid), .in_ready (in_ready), .req_type (req_type),
        .out_valid (out_valid), .out_ready (out_ready),
        .stat (stat), .cmd (cmd)
    );

    mfr_datapath u_dp (
        .clk (clk), .rst_n (rst_n), .cmd (cmd), .stat (stat),
        .req_type (req_type), .x_a (x_a), .y_a (y_a), .x_b (x_b), .y_b (y_b),
        .radius (radius), .quadrant (quadrant), .dot (dot),
        .read_page (read_page), .read_column (read_column),
        .read_byte (read_byte), .is_read (is_read)
    );

    a_ready_blocks_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("new request taken while result stalled");
    a_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_read) |-> (read_byte == 8'd0))
        else $error("nonzero data on non-read result");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted back to back");
endmodule

>>> design/mfr_ram.sv
module mfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/mfr_datapath.sv
module mfr_datapath
    import mfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mfr_cmd_t    cmd,
    output mfr_stat_t   stat,
    input  logic [2:0]  req_type,
    input  logic [7:0]  x_a,
    input  logic [7:0]  y_a,
    input  logic [7:0]  x_b,
    input  logic [7:0]  y_b,
    input  logic [7:0]  radius,
    input  logic [2:0]  quadrant,
    input  logic        dot,
    input  logic [2:0]  read_page,
    input  logic [6:0]  read_column,
    output logic [7:0]  read_byte,
    output logic        is_read
);
    // request
    logic [2:0]  req_reg;
    logic [7:0]  xa_reg, ya_reg, xb_reg, yb_reg;
    logic [2:0]  quad_reg;
    logic        dot_reg;
    logic [2:0]  read_page_reg;
    logic [6:0]  read_col_reg;
    // line walker
    logic signed [9:0] cx_reg, cy_reg, cx_next, cy_next;
    logic [8:0]  dx_reg, dy_reg, dist_reg, ex_reg, ey_reg;
    logic        sxn_reg, syn_reg, sxz_reg, syz_reg;
    logic [8:0]  t_reg;
    // arc walker
    logic signed [9:0] a_reg, b_reg;
    logic signed [12:0] d_reg;
    logic        arc_second_reg;
    // fill walker
    logic [8:0]  fx_reg, fy_reg;
    // store
    logic [ADDR_W-1:0] clr_reg, addr_reg, raddr;
    logic [7:0]  bit_reg, rdata, wdata;
    logic        we;
    logic        inr_reg;
    logic [7:0]  rb_reg;
    logic        isr_reg;

    // current plot coordinate
    logic signed [9:0] px, py;
    logic [7:0] pxw, pyw;
    logic [ADDR_W-1:0] paddr;
    logic [7:0] pbit;
    logic pin;

    always_comb
    begin
        px = cx_reg;
        py = cy_reg;
        unique case (req_reg)
            REQ_ARC:
            begin
                unique case (quad_reg)
                    3'd1: begin px = arc_second_reg ? $signed({2'b0, xa_reg}) + a_reg : $signed({2'b0, xa_reg}) + b_reg;
                                py = arc_second_reg ? $signed({2'b0, ya_reg}) + b_reg : $signed({2'b0, ya_reg}) + a_reg; end
                    3'd2: begin px = arc_second_reg ? $signed({2'b0, xa_reg}) - b_reg : $signed({2'b0, xa_reg}) - a_reg;
                                py = arc_second_reg ? $signed({2'b0, ya_reg}) + a_reg : $signed({2'b0, ya_reg}) + b_reg; end
                    3'd3: begin px = arc_second_reg ? $signed({2'b0, xa_reg}) - b_reg : $signed({2'b0, xa_reg}) - a_reg;
                                py = arc_second_reg ? $signed({2'b0, ya_reg}) - a_reg : $signed({2'b0, ya_reg}) - b_reg; end
                    default: begin px = arc_second_reg ? $signed({2'b0, xa_reg}) + b_reg : $signed({2'b0, xa_reg}) + a_reg;
                                py = arc_second_reg ? $signed({2'b0, ya_reg}) - a_reg : $signed({2'b0, ya_reg}) - b_reg; end
                endcase
            end
            REQ_FILL:
            begin
                px = $signed({1'b0, fx_reg});
                py = $signed({1'b0, fy_reg});
            end
            REQ_POINT:
            begin
                px = $signed({2'b0, xa_reg});
                py = $signed({2'b0, ya_reg});
            end
            default:
            begin
                px = cx_reg;
                py = cy_reg;
            end
        endcase
        pxw = px[7:0];
        pyw = py[7:0];
        pin = ({24'd0, pxw} < SCREEN_COLUMNS) && ({24'd0, pyw} < SCREEN_ROWS);
        paddr = ADDR_W'(({24'd0, pxw} * SCREEN_PAGES)
                + (SCREEN_PAGES - 1) - {27'd0, pyw[7:3]});
        pbit = 8'(8'h80 >> pyw[2:0]);
    end

    // done condition for each walker
    logic arc_done, line_done, fill_done;
    // the line plots dist+2 points, the start point twice
    assign line_done = (t_reg > dist_reg + 9'd1);
    assign arc_done  = (quad_reg < 3'd1) || (quad_reg > 3'd4) || (a_reg > b_reg);
    assign fill_done = (xa_reg > xb_reg) || (ya_reg > yb_reg) || (fx_reg > {1'b0, xb_reg});

    always_comb
    begin
        unique case (req_reg)
            REQ_LINE: stat.done = line_done;
            REQ_ARC:  stat.done = arc_done;
            REQ_FILL: stat.done = fill_done;
            default:  stat.done = 1'b0;
        endcase
    end
    assign stat.in_range = pin;
    assign stat.clr_last = (clr_reg == ADDR_W'(STORE_DEPTH - 1));

    // line step
    logic [8:0] ex_s, ey_s;
    always_comb
    begin
        ex_s = ex_reg + dx_reg;
        ey_s = ey_reg + dy_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (ex_s > dist_reg)
        begin
            cx_next = sxz_reg ? cx_reg : (sxn_reg ? cx_reg - 10'sd1 : cx_reg + 10'sd1);
        end
        if (ey_s > dist_reg)
        begin
            cy_next = syz_reg ? cy_reg : (syn_reg ? cy_reg - 10'sd1 : cy_reg + 10'sd1);
        end
    end

    logic [8:0] adx, ady;
    assign adx = (x_b >= x_a) ? {1'b0, x_b - x_a} : {1'b0, x_a - x_b};
    assign ady = (y_b >= y_a) ? {1'b0, y_b - y_a} : {1'b0, y_a - y_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            isr_reg <= 1'b0;
            rb_reg  <= '0;
            req_reg <= REQ_READ;
        end
        else
        begin
            if (cmd.clr_addr) clr_reg <= '0;
            if (cmd.clr_step) clr_reg <= clr_reg + ADDR_W'(1);
            if (cmd.load)
            begin
                req_reg  <= req_type;
                xa_reg   <= x_a;
                ya_reg   <= y_a;
                xb_reg   <= x_b;
                yb_reg   <= y_b;
                quad_reg <= quadrant;
                dot_reg  <= dot;
                cx_reg   <= $signed({2'b0, x_a});
                cy_reg   <= $signed({2'b0, y_a});
                dx_reg   <= adx;
                dy_reg   <= ady;
                dist_reg <= (adx > ady) ? adx : ady;
                sxn_reg  <= x_b < x_a;
                syn_reg  <= y_b < y_a;
                sxz_reg  <= x_b == x_a;
                syz_reg  <= y_b == y_a;
                ex_reg   <= '0;
                ey_reg   <= '0;
                t_reg    <= '0;
                a_reg    <= '0;
                b_reg    <= $signed({2'b0, radius});
                d_reg    <= 13'sd3 - $signed({4'b0, radius, 1'b0});
                arc_second_reg <= 1'b0;
                fx_reg   <= {1'b0, x_a};
                fy_reg   <= {1'b0, y_a};
            end
            if (cmd.probe)
            begin
                addr_reg <= paddr;
                bit_reg  <= pbit;
                inr_reg  <= pin;
            end
            if (cmd.advance)
            begin
                unique case (req_reg)
                    REQ_LINE:
                    begin
                        t_reg  <= t_reg + 9'd1;
                        cx_reg <= cx_next;
                        cy_reg <= cy_next;
                        ex_reg <= (ex_s > dist_reg) ? ex_s - dist_reg : ex_s;
                        ey_reg <= (ey_s > dist_reg) ? ey_s - dist_reg : ey_s;
                    end
                    REQ_ARC:
                    begin
                        arc_second_reg <= ~arc_second_reg;
                        if (arc_second_reg)
                        begin
                            a_reg <= a_reg + 10'sd1;
                            if (d_reg < 0)
                            begin
                                d_reg <= d_reg + 13'(4 * (a_reg + 10'sd1)) + 13'sd6;
                            end
                            else
                            begin
                                d_reg <= d_reg + 13'sd10 + 13'(4 * (a_reg + 10'sd1 - b_reg));
                                b_reg <= b_reg - 10'sd1;
                            end
                        end
                    end
                    REQ_FILL:
                    begin
                        if (fy_reg >= {1'b0, yb_reg})
                        begin
                            fy_reg <= {1'b0, ya_reg};
                            fx_reg <= fx_reg + 9'd1;
                        end
                        else
                        begin
                            fy_reg <= fy_reg + 9'd1;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.rd_take)
            begin
                isr_reg <= 1'b1;
                rb_reg  <= (read_page_reg < SCREEN_PAGES && read_col_reg < SCREEN_COLUMNS)
                           ? rdata : 8'd0;
            end
            if (cmd.res_zero)
            begin
                isr_reg <= 1'b0;
                rb_reg  <= 8'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            read_page_reg <= read_page;
            read_col_reg  <= read_column;
        end
    end

    assign raddr = cmd.rd_issue
        ? ADDR_W'({25'd0, read_col_reg} * SCREEN_PAGES + {29'd0, read_page_reg})
        : paddr;

    always_comb
    begin
        we = cmd.clr_step || (cmd.write && inr_reg);
        if (cmd.clr_step)
        begin
            wdata = 8'd0;
        end
        else if (req_reg == REQ_POINT && !dot_reg)
        begin
            wdata = rdata & ~bit_reg;
        end
        else
        begin
            wdata = rdata | bit_reg;
        end
    end

    mfr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (cmd.clr_step ? clr_reg : addr_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign read_byte = rb_reg;
    assign is_read   = isr_reg;
endmodule

>>> design/mfr_ctrl.sv
module mfr_ctrl
    import mfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [2:0] req_type,
    output logic      out_valid,
    input  logic      out_ready,
    input  mfr_stat_t stat,
    output mfr_cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_PROBE, S_WRITE, S_READ, S_TAKE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   single_reg;

    logic accept;
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_CLEAR:    cmd.clr_step = 1'b1;
            S_IDLE:     cmd.load = accept;
            S_DISPATCH: cmd.rd_issue = 1'b1;
            S_PROBE:    cmd.probe = !stat.done;
            S_WRITE:
            begin
                cmd.write    = 1'b1;
                cmd.advance  = 1'b1;
                cmd.res_zero = single_reg;
            end
            // hold the read address so the data arrives in S_TAKE
            S_READ:     cmd.rd_issue = 1'b1;
            S_TAKE:
            begin
                cmd.rd_take  = !single_reg;
                cmd.res_zero = single_reg;
            end
            default:    ;
        endcase
        if (state_reg == S_PROBE && stat.done)
        begin
            cmd.res_zero = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            single_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                    if (stat.clr_last) state_reg <= S_IDLE;
                S_IDLE:
                    if (accept)
                    begin
                        // point: one plot; unknown request: result only
                        single_reg <= (req_type == REQ_POINT) || (req_type > REQ_READ);
                        priority if (req_type == REQ_READ)
                            state_reg <= S_DISPATCH;
                        else if (req_type == REQ_POINT || req_type == REQ_LINE
                                 || req_type == REQ_ARC || req_type == REQ_FILL)
                            state_reg <= S_PROBE;
                        else
                            state_reg <= S_TAKE;
                    end
                S_DISPATCH: state_reg <= S_READ;
                S_READ:     state_reg <= S_TAKE;
                S_TAKE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_PROBE:
                    if (stat.done)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                S_WRITE:
                    if (single_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_PROBE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> tb/sv/mono_framebuffer_rasterizer_tb.sv
`timescale 1ns / 100ps

module mono_framebuffer_rasterizer_tb;
    import mfr_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] req_type;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic [7:0] radius;
    logic [2:0] quadrant;
    logic       dot;
    logic [2:0] read_page;
    logic [6:0] read_column;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_byte;
    logic       is_read;

    typedef struct packed {
        logic [7:0] rbyte;
        logic       rd;
    } read_result_t;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [2:0] REQ_UNKNOWN = 3'd5;

    logic [7:0]   pixel_bytes [STORE_DEPTH];
    read_result_t pending_results[$];
    int           mismatch_count;
    int           cycle_count;
    bit           stall_free;

    mono_framebuffer_rasterizer dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .x_a(x_a), .y_a(y_a), .x_b(x_b), .y_b(y_b),
        .radius(radius), .quadrant(quadrant), .dot(dot), .read_page(read_page),
        .read_column(read_column), .out_valid(out_valid), .out_ready(out_ready),
        .read_byte(read_byte), .is_read(is_read)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** mono_framebuffer_rasterizer: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Predictor: pixel plotting with 8-bit wrap and clip
    function automatic void plot_pixel(input int xs, input int ys, input bit on);
        int x;
        int y;
        int idx;
        x = xs & 255;
        y = ys & 255;
        if (x >= SCREEN_COLUMNS || y >= SCREEN_ROWS)
            return;
        idx = x * SCREEN_PAGES + (SCREEN_PAGES - 1 - y / 8);
        if (on)
            pixel_bytes[idx] |= 8'h80 >> (y % 8);
        else
            pixel_bytes[idx] &= ~(8'h80 >> (y % 8));
    endfunction

    function automatic void rasterize_line(input int x1, input int y1, input int x2, input int y2);
        int dx;
        int dy;
        int sx;
        int sy;
        int span;
        int ex;
        int ey;
        int cx;
        int cy;
        dx = x2 - x1;
        dy = y2 - y1;
        sx = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
        sy = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        span = (dx > dy) ? dx : dy;
        ex = 0;
        ey = 0;
        cx = x1;
        cy = y1;
        for (int t = 0; t <= span + 1; t++)
        begin
            plot_pixel(cx, cy, 1'b1);
            ex += dx;
            ey += dy;
            if (ex > span)
            begin
                ex -= span;
                cx += sx;
            end
            if (ey > span)
            begin
                ey -= span;
                cy += sy;
            end
        end
    endfunction

    function automatic void rasterize_arc(input int x0, input int y0, input int r, input int q);
        int a;
        int b;
        int d;
        a = 0;
        b = r;
        d = 3 - 2 * r;
        if (q < 1 || q > 4)
            return;
        while (a <= b)
        begin
            case (q)
                1: begin plot_pixel(x0 + b, y0 + a, 1); plot_pixel(x0 + a, y0 + b, 1); end
                2: begin plot_pixel(x0 - a, y0 + b, 1); plot_pixel(x0 - b, y0 + a, 1); end
                3: begin plot_pixel(x0 - a, y0 - b, 1); plot_pixel(x0 - b, y0 - a, 1); end
                default: begin plot_pixel(x0 + a, y0 - b, 1); plot_pixel(x0 + b, y0 - a, 1); end
            endcase
            a++;
            if (d < 0)
                d += 4 * a + 6;
            else
            begin
                d += 10 + 4 * (a - b);
                b--;
            end
        end
    endfunction

    function automatic read_result_t apply_request(input logic [2:0] rq, input logic [7:0] xa,
        input logic [7:0] ya, input logic [7:0] xb, input logic [7:0] yb, input logic [7:0] rad,
        input logic [2:0] q, input logic d, input logic [2:0] pg, input logic [6:0] col);
        read_result_t res;
        res = '0;
        case (rq)
            REQ_POINT: plot_pixel(xa, ya, d);
            REQ_LINE:  rasterize_line(xa, ya, xb, yb);
            REQ_ARC:   rasterize_arc(xa, ya, rad, q);
            REQ_FILL:
                for (int x = xa; x <= xb; x++)
                    for (int y = ya; y <= yb; y++)
                        plot_pixel(x, y, 1'b1);
            REQ_READ:
            begin
                res.rd = 1'b1;
                if (pg < SCREEN_PAGES && col < SCREEN_COLUMNS)
                    res.rbyte = pixel_bytes[col * SCREEN_PAGES + pg];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Drive one transaction; valid stays high into the next one unless the sender idles
    task automatic send_request(input logic [2:0] rq, input logic [7:0] xa, input logic [7:0] ya,
        input logic [7:0] xb, input logic [7:0] yb, input logic [7:0] rad, input logic [2:0] q,
        input logic d, input logic [2:0] pg, input logic [6:0] col);
        @(negedge clk);
        while (!stall_free && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req_type <= rq;
        x_a <= xa;
        y_a <= ya;
        x_b <= xb;
        y_b <= yb;
        radius <= rad;
        quadrant <= q;
        dot <= d;
        read_page <= pg;
        read_column <= col;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_request(rq, xa, ya, xb, yb, rad, q, d, pg, col));
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic send_read(input logic [2:0] pg, input logic [6:0] col);
        send_request(REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            8'($urandom), 3'($urandom), 1'($urandom), pg, col);
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                read_result_t exp_res;
                exp_res = pending_results.pop_front();
                if (read_byte !== exp_res.rbyte)
                    report_mismatch($sformatf("read_byte %h expected %h", read_byte,
                        exp_res.rbyte));
                if (is_read !== exp_res.rd)
                    report_mismatch($sformatf("is_read %b expected %b", is_read, exp_res.rd));
            end
        end
    end

    always @(negedge clk)
        out_ready <= stall_free ? 1'b1 : ($urandom_range(99) >= 32);

    task automatic test_points_and_reads();
        send_read(0, 0);
        send_request(REQ_POINT, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        send_request(REQ_POINT, 127, 63, 0, 0, 0, 0, 1, 0, 0);
        send_request(REQ_POINT, 128, 64, 0, 0, 0, 0, 1, 0, 0);
        send_request(REQ_POINT, 255, 255, 0, 0, 0, 0, 1, 0, 0);
        send_read(7, 0);
        send_read(0, 127);
        send_request(REQ_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_read(7, 0);
        send_request(REQ_UNKNOWN, 5, 5, 5, 5, 5, 1, 1, 3, 3);
        send_request(3'd7, 255, 255, 255, 255, 255, 7, 1, 7, 127);
    endtask

    task automatic test_lines_arcs_fills();
        send_request(REQ_LINE, 10, 10, 10, 10, 0, 0, 0, 0, 0);
        send_request(REQ_LINE, 0, 63, 255, 0, 0, 0, 0, 0, 0);
        send_request(REQ_LINE, 250, 5, 3, 60, 0, 0, 0, 0, 0);
        send_request(REQ_ARC, 64, 32, 20, 1, 0, 0, 0, 0, 0);
        send_request(REQ_ARC, 64, 32, 255, 2, 0, 0, 0, 0, 0);
        send_request(REQ_ARC, 5, 5, 10, 3, 0, 0, 0, 0, 0);
        send_request(REQ_ARC, 120, 2, 0, 4, 0, 0, 0, 0, 0);
        send_request(REQ_ARC, 60, 30, 9, 0, 0, 0, 0, 0, 0);
        send_request(REQ_ARC, 60, 30, 9, 7, 0, 0, 0, 0, 0);
        send_request(REQ_FILL, 20, 10, 30, 20, 0, 0, 0, 0, 0);
        send_request(REQ_FILL, 30, 10, 20, 20, 0, 0, 0, 0, 0);
        send_request(REQ_FILL, 125, 60, 255, 255, 0, 0, 0, 0, 0);
        send_read(7, 64);
        send_read(0, 126);
    endtask

    task automatic test_random_drawing(input int count);
        logic [7:0] xa;
        logic [7:0] ya;
        logic [7:0] w;
        logic [7:0] h;
        for (int i = 0; i < count; i++)
        begin
            stall_free = (i >= count / 3 && i < count / 2);
            if (i == count / 2)
            begin
                release_input();
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            xa = 8'($urandom);
            ya = 8'($urandom);
            case ($urandom_range(9))
                0, 1: send_request(REQ_POINT, 8'($urandom_range(0, 140)),
                    8'($urandom_range(0, 70)), 8'($urandom), 8'($urandom), 8'($urandom),
                    3'($urandom), 1'($urandom), 3'($urandom), 7'($urandom));
                2: send_request(REQ_LINE, xa, ya, 8'($urandom), 8'($urandom), 8'($urandom),
                    3'($urandom), 1'($urandom), 3'($urandom), 7'($urandom));
                3: send_request(REQ_LINE, 8'($urandom_range(127)), 8'($urandom_range(63)),
                    8'($urandom_range(127)), 8'($urandom_range(63)), 0, 0, 0, 0, 0);
                4: send_request(REQ_ARC, 8'($urandom_range(127)), 8'($urandom_range(63)),
                    0, 0, ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(40)),
                    3'($urandom), 0, 0, 0);
                5:
                begin
                    w = 8'($urandom_range(12));
                    h = 8'($urandom_range(12));
                    if ($urandom_range(7) == 0)
                        send_request(REQ_FILL, 8'd250, 8'd250, 8'd255, 8'd255, 0, 0, 0, 0, 0);
                    else
                        send_request(REQ_FILL, xa, ya, xa + w, ya + h, 8'($urandom),
                            3'($urandom), 1'($urandom), 0, 0);
                end
                6: send_request(3'($urandom_range(5, 7)), xa, ya, 8'($urandom), 8'($urandom),
                    8'($urandom), 3'($urandom), 1'($urandom), 3'($urandom), 7'($urandom));
                default: send_read(3'($urandom), 7'($urandom));
            endcase
        end
        stall_free = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        req_type = '0;
        x_a = '0;
        y_a = '0;
        x_b = '0;
        y_b = '0;
        radius = '0;
        quadrant = '0;
        dot = 1'b0;
        read_page = '0;
        read_column = '0;
        mismatch_count = 0;
        cycle_count = 0;
        stall_free = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            pixel_bytes[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_points_and_reads();
        test_lines_arcs_fills();
        test_random_drawing(700);
        release_input();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (mismatch_count == 0)
            $display("** mono_framebuffer_rasterizer: PASSED **");
        else
            $display("** mono_framebuffer_rasterizer: FAILED **");
        $finish;
    end

endmodule
